/* rtl/hvt_pkg.sv */
// Package with constants and types shared by the homogeneous vertex transform unit.
`default_nettype none
package hvt_pkg;
	localparam int FRAC_BITS = 16;
	localparam int NUM_PAIRS = 8;
	localparam int NUM_LANES = 3;
	localparam int QW        = 32 + FRAC_BITS;   // dividend magnitude width
	localparam int PSUM_W    = 66;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef logic signed [31:0] s32_t;

	// Status carried alongside the lanes through the divide pipeline.
	typedef struct packed {
		logic valid;
		logic zero_w;
		logic sat;
	} hvt_ctl_t;

	// Clamp a wide signed value to 32 bits and report the clamp.
	function automatic logic [32:0] clamp_sum(input logic signed [PSUM_W-FRAC_BITS-1:0] v);
		logic [32:0] r;
		if (v > $signed({{(PSUM_W-FRAC_BITS-32){1'b0}}, S32_MAX}))
			r = {1'b1, S32_MAX};
		else if (v < $signed({{(PSUM_W-FRAC_BITS-32){1'b1}}, S32_MIN}))
			r = {1'b1, S32_MIN};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/homogeneous_vertex_transform_unit.sv */
// Top level of the homogeneous vertex transform unit with perspective divide.
//   channel   | signals                                  | direction
//   request   | start, busy, in_x..in_w                  | in (busy: out)
//   result    | done, out_x..out_w, saturated, zero_w    | out
//   config    | psel, penable, pwrite, paddr, pwdata...  | in/out
// One request is accepted every cycle; busy is always low.
// From accept to done the pipeline registers are: the products, registered at the
// accepting edge, then the column sums, the divide setup, the divider input
// stage, 48 divider stages, the lane output and the output register.
// Reset clears the pipeline valids and loads the identity matrix.
// The receiver cannot stall; done pulses for one cycle per request.
`default_nettype none
module homogeneous_vertex_transform_unit import hvt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [31:0]   in_x,
	input  wire logic signed [31:0]   in_y,
	input  wire logic signed [31:0]   in_z,
	input  wire logic signed [31:0]   in_w,
	output logic                      done,
	output logic signed [31:0]        out_x,
	output logic signed [31:0]        out_y,
	output logic signed [31:0]        out_z,
	output logic [FRAC_BITS:0]        out_w,
	output logic                      saturated,
	output logic                      zero_w,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [5:0]           paddr,
	input  wire logic [63:0]          pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);
	localparam int LAT = QW + 1;

	logic [63:0] pair_q [NUM_PAIRS];
	s32_t        vin [4];
	s32_t        col_m [4][4];
	logic [31:0] t_s2 [4];
	logic        csat_s2 [4];
	logic [31:0] num_s3 [NUM_LANES];
	logic [31:0] den_s3;
	hvt_ctl_t    ctl_q [LAT+4];
	logic [31:0] sgn_q [NUM_LANES][LAT+2];
	logic [31:0] q_lane [NUM_LANES];
	logic        qsat_lane [NUM_LANES];
	logic [31:0] res [NUM_LANES];
	logic        dsat;
	logic        wr_en;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = pair_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PAIRS; p++)
				pair_q[p] <= '0;
			pair_q[0] <= 64'd65536;
			pair_q[2] <= 64'd65536 << 32;
			pair_q[5] <= 64'd65536;
			pair_q[7] <= 64'd65536 << 32;
		end else if (wr_en) begin
			pair_q[paddr[5:3]] <= pwdata;
		end
	end

	assign vin[0] = in_x;
	assign vin[1] = in_y;
	assign vin[2] = in_z;
	assign vin[3] = in_w;

	for (genvar j = 0; j < 4; j++) begin : g_col
		for (genvar i = 0; i < 4; i++) begin : g_m
			localparam int K = 4 * i + j;
			assign col_m[j][i] = (K % 2 == 1) ? pair_q[K/2][63:32] : pair_q[K/2][31:0];
		end
		hvt_column u_col (.clk(clk), .v(vin), .m(col_m[j]), .t_s2(t_s2[j]),
			.sat_s2(csat_s2[j]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT + 4; k++)
				ctl_q[k] <= '0;
		end else begin
			ctl_q[0] <= '{valid: start, zero_w: 1'b0, sat: 1'b0};
			ctl_q[1] <= ctl_q[0];
			ctl_q[2] <= '{valid: ctl_q[1].valid, zero_w: t_s2[3] == '0,
				sat: csat_s2[0] | csat_s2[1] | csat_s2[2] | csat_s2[3]};
			for (int k = 3; k < LAT + 4; k++)
				ctl_q[k] <= ctl_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			num_s3[l]   <= t_s2[l];
			sgn_q[l][0] <= t_s2[l];
			for (int k = 1; k <= LAT + 1; k++)
				sgn_q[l][k] <= sgn_q[l][k-1];
		end
		den_s3 <= (t_s2[3] == '0) ? 32'd1 : t_s2[3];
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
		hvt_div_lane u_div (.clk(clk), .num(num_s3[l]), .den(den_s3),
			.q_out(q_lane[l]), .sat_out(qsat_lane[l]));
	end

	// Merge: pick quotient or sign substitution, combine clamp flags.
	always_comb begin
		dsat = 1'b0;
		for (int l = 0; l < NUM_LANES; l++) begin
			if (ctl_q[LAT+3].zero_w) begin
				if (sgn_q[l][LAT+1] == '0)
					res[l] = '0;
				else
					res[l] = sgn_q[l][LAT+1][31] ? S32_MIN : S32_MAX;
			end else begin
				res[l] = q_lane[l];
				dsat   = dsat | qsat_lane[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= ctl_q[LAT+3].valid;
	end

	always_ff @(posedge clk) begin
		out_x     <= res[0];
		out_y     <= res[1];
		out_z     <= res[2];
		out_w     <= ctl_q[LAT+3].zero_w ? '0 : (FRAC_BITS+1)'(1 << FRAC_BITS);
		saturated <= ctl_q[LAT+3].sat | dsat;
		zero_w    <= ctl_q[LAT+3].zero_w;
	end
endmodule
`default_nettype wire

/* rtl/hvt_column.sv */
// One matrix column: four products, registered, then summed, shifted and clamped.
`default_nettype none
module hvt_column import hvt_pkg::*; (
	input  wire logic        clk,
	input  wire s32_t        v [4],
	input  wire s32_t        m [4],
	output logic      [31:0] t_s2,
	output logic             sat_s2
);
	logic signed [63:0] prod_s1 [4];
	logic signed [PSUM_W-1:0] sum;
	logic signed [PSUM_W-FRAC_BITS-1:0] shifted;
	logic [32:0] cl;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			prod_s1[i] <= v[i] * m[i];
	end

	// Dropping the low bits of the exact sum gives its floor.
	always_comb begin
		sum = PSUM_W'(prod_s1[0]) + PSUM_W'(prod_s1[1]) + PSUM_W'(prod_s1[2])
			+ PSUM_W'(prod_s1[3]);
		shifted = sum[PSUM_W-1:FRAC_BITS];
		cl = clamp_sum(shifted);
	end

	always_ff @(posedge clk) begin
		t_s2   <= cl[31:0];
		sat_s2 <= cl[32];
	end
endmodule
`default_nettype wire

/* rtl/hvt_div_lane.sv */
// Pipelined restoring divider lane, one quotient bit per stage, with clamp.
`default_nettype none
module hvt_div_lane import hvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic      [31:0] q_out,
	output logic             sat_out
);
	logic [QW-1:0] n_q   [QW+1];
	logic [QW-1:0] rem_q [QW+1];
	logic [31:0]   d_q   [QW+1];
	logic          neg_q [QW+1];
	logic [QW:0]   mag;
	logic [QW:0]   lim;
	logic [31:0]   res;
	logic          sat;

	// Stage 0 takes magnitudes; the dividend is num shifted up by FRAC_BITS.
	always_ff @(posedge clk) begin
		n_q[0]   <= {(num[31] ? 32'(-num) : num), {FRAC_BITS{1'b0}}};
		rem_q[0] <= '0;
		d_q[0]   <= den[31] ? 32'(-den) : den;
		neg_q[0] <= num[31] ^ den[31];
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [QW:0] trial;
		logic [QW:0] sh;
		always_comb begin
			sh    = {rem_q[k], n_q[k][QW-1]};
			trial = sh - (QW+1)'(d_q[k]);
		end
		always_ff @(posedge clk) begin
			if (!trial[QW]) begin
				rem_q[k+1] <= trial[QW-1:0];
				n_q[k+1]   <= {n_q[k][QW-2:0], 1'b1};
			end else begin
				rem_q[k+1] <= sh[QW-1:0];
				n_q[k+1]   <= {n_q[k][QW-2:0], 1'b0};
			end
			d_q[k+1]   <= d_q[k];
			neg_q[k+1] <= neg_q[k];
		end
	end

	// After all stages n_q holds the quotient magnitude.
	always_comb begin
		mag = {1'b0, n_q[QW]};
		lim = neg_q[QW] ? (QW+1)'(33'h080000000) : (QW+1)'(32'h7fffffff);
		sat = mag > lim;
		if (sat)
			res = neg_q[QW] ? S32_MIN : S32_MAX;
		else
			res = neg_q[QW] ? 32'(-mag) : mag[31:0];
	end

	always_ff @(posedge clk) begin
		q_out   <= res;
		sat_out <= sat;
	end
endmodule
`default_nettype wire

/* rtl/hvt_checker.sv */
// Port-level checker for the homogeneous vertex transform unit, with its bind.
`default_nettype none
module hvt_checker import hvt_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [FRAC_BITS:0] out_w,
	input wire logic              zero_w,
	input wire logic              pready
);
	a_idle: assert property (@(posedge clk) disable iff (!arst_n) !busy && pready)
		else $error("busy or pready wrong");
	a_w: assert property (@(posedge clk) disable iff (!arst_n)
		done && !zero_w |-> out_w == (FRAC_BITS+1)'(1 << FRAC_BITS))
		else $error("out_w not one");
	a_zw: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_w |-> out_w == '0)
		else $error("out_w not zero");
endmodule

bind homogeneous_vertex_transform_unit hvt_checker u_hvt_checker (.clk(clk),
	.arst_n(arst_n), .busy(busy), .done(done), .out_w(out_w), .zero_w(zero_w),
	.pready(pready));
`default_nettype wire
